>>> src/qate_pkg.sv
`timescale 1ns / 1ps

package qate_pkg;

	// Character codes used by the classifier and the expander.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_H  = 8'h48;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_BQ    = 8'h60;
	localparam logic [7:0] CH_LO_H  = 8'h68;

	// Tab stops fall on multiples of eight columns.
	localparam int unsigned TAB_BITS = 3;
	localparam int unsigned TAB_STOP = 1 << TAB_BITS;

	// Width of a padding count, which runs from one to TAB_STOP.
	localparam int unsigned CNT_W = TAB_BITS + 1;

	// Depth of the queue between the classifier and the expander.
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	// Quoting state of the current line.
	typedef enum logic [2:0] {
		QM_NONE = 3'd0,
		QM_DQ   = 3'd1,
		QM_SQ   = 3'd2,
		QM_BQ   = 3'd3,
		QM_LINE = 3'd4
	} quote_mode_t;

	// What the expander has to do with one queued item.
	typedef enum logic [1:0] {
		ENT_CHAR = 2'd0,
		ENT_TAB  = 2'd1,
		ENT_EOL  = 2'd2
	} entry_kind_t;

	typedef struct packed {
		entry_kind_t      kind;
		logic [7:0]       data;
		logic [CNT_W-1:0] count;
		logic             trunc;
	} entry_t;

endpackage

>>> src/qate_front.sv
`timescale 1ns / 1ps

module qate_front #(
	parameter int unsigned LINE_SIZE = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       char_in,
	input  logic             end_of_line,
	input  logic             fifo_full,
	output logic             push,
	output qate_pkg::entry_t push_entry
);

	localparam int unsigned CW = $clog2(LINE_SIZE);
	localparam logic [CW-1:0] LIMIT = CW'(LINE_SIZE - 1);

	logic [CW-1:0]         column_q;
	qate_pkg::quote_mode_t quote_q;
	logic                  prev_bsl_q;
	logic                  prev_digit_q;

	logic                  accept;
	logic                  at_limit;
	logic                  is_tab;
	logic                  is_digit;
	logic                  is_h;
	logic [CW-1:0]         room;
	logic [qate_pkg::CNT_W-1:0] to_stop;
	logic [qate_pkg::CNT_W-1:0] pad;
	qate_pkg::quote_mode_t open_code;
	logic [7:0]            close_ch;
	qate_pkg::quote_mode_t quote_next;

	// Items are taken whenever the queue has room.
	assign in_stall = fifo_full;
	assign accept   = in_valid && !fifo_full;

	assign at_limit = (column_q >= LIMIT);
	assign is_tab   = (char_in == qate_pkg::CH_TAB) && (quote_q == qate_pkg::QM_NONE);
	assign is_digit = (char_in >= qate_pkg::CH_ZERO) && (char_in <= qate_pkg::CH_NINE);
	assign is_h     = (char_in == qate_pkg::CH_LO_H) || (char_in == qate_pkg::CH_UP_H);

	// Padding runs to the next tab stop, cut at the column limit.
	assign room    = LIMIT - column_q;
	assign to_stop = qate_pkg::CNT_W'(qate_pkg::TAB_STOP)
		- {1'b0, column_q[qate_pkg::TAB_BITS-1:0]};
	assign pad     = (room < CW'(to_stop)) ? room[qate_pkg::CNT_W-1:0] : to_stop;

	// Quote character that opens a quote, and the one that closes the current one.
	always_comb begin
		unique case (char_in)
			qate_pkg::CH_DQ: open_code = qate_pkg::QM_DQ;
			qate_pkg::CH_SQ: open_code = qate_pkg::QM_SQ;
			qate_pkg::CH_BQ: open_code = qate_pkg::QM_BQ;
			default:         open_code = qate_pkg::QM_NONE;
		endcase
	end

	always_comb begin
		unique case (quote_q)
			qate_pkg::QM_DQ:   close_ch = qate_pkg::CH_DQ;
			qate_pkg::QM_SQ:   close_ch = qate_pkg::CH_SQ;
			qate_pkg::QM_BQ:   close_ch = qate_pkg::CH_BQ;
			qate_pkg::QM_LINE: close_ch = qate_pkg::CH_NL;
			default:           close_ch = qate_pkg::CH_NUL;
		endcase
	end

	// Quote state after an ordinary character.
	always_comb begin
		quote_next = quote_q;
		if (quote_q == qate_pkg::QM_NONE) begin
			if (!prev_bsl_q) begin
				quote_next = open_code;
			end
		end else if (!prev_bsl_q && char_in == close_ch) begin
			quote_next = qate_pkg::QM_NONE;
		end
		if (prev_digit_q && is_h) begin
			quote_next = qate_pkg::QM_LINE;
		end
	end

	// Classification of the item into a queue entry.
	always_comb begin
		push             = 1'b0;
		push_entry.kind  = qate_pkg::ENT_CHAR;
		push_entry.data  = char_in;
		push_entry.count = pad;
		push_entry.trunc = at_limit;
		if (end_of_line) begin
			push            = accept;
			push_entry.kind = qate_pkg::ENT_EOL;
		end else if (char_in != qate_pkg::CH_NUL && !at_limit) begin
			push = accept;
			if (is_tab) begin
				push_entry.kind = qate_pkg::ENT_TAB;
			end
		end
	end

	// Line state; a line end returns everything to its reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q     <= '0;
			quote_q      <= qate_pkg::QM_NONE;
			prev_bsl_q   <= 1'b0;
			prev_digit_q <= 1'b0;
		end else if (accept) begin
			if (end_of_line) begin
				column_q     <= '0;
				quote_q      <= qate_pkg::QM_NONE;
				prev_bsl_q   <= 1'b0;
				prev_digit_q <= 1'b0;
			end else if (char_in != qate_pkg::CH_NUL && !at_limit) begin
				if (is_tab) begin
					column_q <= column_q + CW'(pad);
				end else begin
					column_q <= column_q + CW'(1);
					quote_q  <= quote_next;
				end
				prev_bsl_q   <= (char_in == qate_pkg::CH_BSL);
				prev_digit_q <= is_digit;
			end
		end
	end

endmodule

>>> src/qate_fifo.sv
`timescale 1ns / 1ps

module qate_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  qate_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output qate_pkg::entry_t head
);

	qate_pkg::entry_t                 slots_q [qate_pkg::FIFO_DEPTH];
	logic [qate_pkg::FIFO_AW-1:0]     wr_ptr_q;
	logic [qate_pkg::FIFO_AW-1:0]     rd_ptr_q;
	logic [qate_pkg::FIFO_AW:0]       count_q;

	assign full       = (count_q == (qate_pkg::FIFO_AW+1)'(qate_pkg::FIFO_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slots_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + qate_pkg::FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + qate_pkg::FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (qate_pkg::FIFO_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (qate_pkg::FIFO_AW+1)'(1);
			end
		end
	end

endmodule

>>> src/qate_back.sv
`timescale 1ns / 1ps

module qate_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  qate_pkg::entry_t head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       char_out,
	output logic             last_of_run,
	output logic             line_done,
	output logic             line_truncated
);

	logic                         valid_q;
	logic [7:0]                   char_q;
	logic                         last_q;
	logic                         done_q;
	logic                         trunc_q;
	logic [qate_pkg::TAB_BITS-1:0] sent_q;

	logic       load;
	logic [7:0] nxt_char;
	logic       nxt_last;
	logic       nxt_done;
	logic       nxt_trunc;

	// The output register is refilled whenever the queue has an entry and the register is empty or being taken.
	assign load = head_valid && (!valid_q || !out_stall);
	assign pop  = load && nxt_last;

	// Next result from the head entry; a tab yields one space per cycle while the output is not stalled.
	always_comb begin
		nxt_char  = head.data;
		nxt_last  = 1'b1;
		nxt_done  = 1'b0;
		nxt_trunc = 1'b0;
		unique case (head.kind)
			qate_pkg::ENT_TAB: begin
				nxt_char = qate_pkg::CH_SPACE;
				nxt_last = ({1'b0, sent_q} + qate_pkg::CNT_W'(1)) == head.count;
			end
			qate_pkg::ENT_EOL: begin
				nxt_char  = qate_pkg::CH_NUL;
				nxt_done  = 1'b1;
				nxt_trunc = head.trunc;
			end
			qate_pkg::ENT_CHAR: begin
				nxt_char = head.data;
			end
			default: begin
				nxt_char = head.data;
			end
		endcase
	end

	// Output valid and the padding counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sent_q  <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sent_q  <= nxt_last ? '0 : sent_q + qate_pkg::TAB_BITS'(1);
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			char_q  <= nxt_char;
			last_q  <= nxt_last;
			done_q  <= nxt_done;
			trunc_q <= nxt_trunc;
		end
	end

	assign out_valid      = valid_q;
	assign char_out       = char_q;
	assign last_of_run    = last_q;
	assign line_done      = done_q;
	assign line_truncated = trunc_q;

endmodule

>>> src/quote_aware_tab_expander_core.sv
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// input     in_valid / in_stall   char_in[7:0], end_of_line
// output    out_valid / out_stall char_out[7:0], last_of_run, line_done, line_truncated
//
// A line end gives one result, and so does an ordinary character unless it is NUL or the
// column limit is reached. A tab outside quotes gives one to eight spaces, one per cycle
// while the output is not stalled, from the expander's single output register, keeping its
// queue entry until the last space. Results pass a queue slot and then the output register.
// Reset clears the line state, the queue and the output register; no clearing pass is needed.
// Input is stalled only when the four-entry queue is full, so input keeps flowing while
// the output is stalled until the queue fills.

module quote_aware_tab_expander_core #(
	parameter int unsigned LINE_SIZE = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_in,
	input  logic       end_of_line,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] char_out,
	output logic       last_of_run,
	output logic       line_done,
	output logic       line_truncated
);

	logic             fifo_full;
	logic             push;
	qate_pkg::entry_t push_entry;
	logic             pop;
	logic             head_valid;
	qate_pkg::entry_t head;

	// Classifier: tracks columns and quoting, decides what each item produces.
	qate_front #(
		.LINE_SIZE (LINE_SIZE)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.char_in     (char_in),
		.end_of_line (end_of_line),
		.fifo_full   (fifo_full),
		.push        (push),
		.push_entry  (push_entry)
	);

	// Queue decoupling the classifier from the expander.
	qate_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (fifo_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// Expander: turns queued entries into result items.
	qate_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head           (head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.char_out       (char_out),
		.last_of_run    (last_of_run),
		.line_done      (line_done),
		.line_truncated (line_truncated)
	);

endmodule
